// ----- rtl/rgbhsv_pkg.sv -----
`default_nettype none

package rgbhsv_pkg;

  // Hue scale and sector bases on the 0..255 circle
  localparam logic [7:0] HUE_STEP   = 8'd43;
  localparam logic [7:0] BASE_RED   = 8'd0;
  localparam logic [7:0] BASE_GREEN = 8'd85;
  localparam logic [7:0] BASE_BLUE  = 8'd171;

  // 43 * 255 fits in 14 bits; the quotient never exceeds 43
  localparam int NUM_W          = 14;
  localparam int DIV_STAGES     = 3;
  localparam int BITS_PER_STAGE = 2;
  localparam int QUO_W          = DIV_STAGES * BITS_PER_STAGE;

  // front (2) + divider + output register
  localparam int PIPE_LAT = 2 + DIV_STAGES + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgbhsv_in_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } rgbhsv_out_t;

  // Per-pixel values that ride along with the division
  typedef struct packed {
    logic       neg;
    logic [7:0] base;
    logic [7:0] span;
    logic [7:0] mx;
  } rgbhsv_side_t;

endpackage

`default_nettype wire

// ----- rtl/rgbhsv_front.sv -----
`default_nettype none

module rgbhsv_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_vld,
  input  wire rgbhsv_pkg::rgbhsv_in_t    in_pix,
  output logic                           num_vld,
  output logic [rgbhsv_pkg::NUM_W-1:0]   num,
  output rgbhsv_pkg::rgbhsv_side_t       num_side
);
  import rgbhsv_pkg::*;

  logic [7:0]   mx, mn, op_a, op_b, mag_nxt;
  rgbhsv_side_t side_nxt;

  logic         s1_vld_r;
  logic [7:0]   s1_mag_r;
  rgbhsv_side_t s1_side_r;

  logic         s2_vld_r;
  logic [NUM_W-1:0] s2_num_r;
  rgbhsv_side_t s2_side_r;

  // Max/min, sector pick (red, then green, then blue on ties), signed difference
  always_comb begin
    mx = in_pix.red;
    mn = in_pix.red;
    if (in_pix.green > mx) mx = in_pix.green;
    if (in_pix.blue > mx) mx = in_pix.blue;
    if (in_pix.green < mn) mn = in_pix.green;
    if (in_pix.blue < mn) mn = in_pix.blue;

    side_nxt.mx   = mx;
    side_nxt.span = mx - mn;
    if (mx == in_pix.red) begin
      side_nxt.base = BASE_RED;
      op_a = in_pix.green;
      op_b = in_pix.blue;
    end else if (mx == in_pix.green) begin
      side_nxt.base = BASE_GREEN;
      op_a = in_pix.blue;
      op_b = in_pix.red;
    end else begin
      side_nxt.base = BASE_BLUE;
      op_a = in_pix.red;
      op_b = in_pix.green;
    end
    side_nxt.neg = op_a < op_b;
    mag_nxt = side_nxt.neg ? (op_b - op_a) : (op_a - op_b);
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
    s1_mag_r  <= mag_nxt;
    s1_side_r <= side_nxt;
  end

  // Stage 2: scale the difference by the hue step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_num_r  <= NUM_W'(s1_mag_r) * NUM_W'(HUE_STEP);
    s2_side_r <= s1_side_r;
  end

  assign num_vld  = s2_vld_r;
  assign num      = s2_num_r;
  assign num_side = s2_side_r;

endmodule

`default_nettype wire

// ----- rtl/rgbhsv_div.sv -----
`default_nettype none

// Restoring divide, two quotient bits per stage, quotient MSB first.
// The numerator is at most 43 * span, so the quotient fits in QUO_W bits.
module rgbhsv_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      num_vld,
  input  wire logic [rgbhsv_pkg::NUM_W-1:0] num,
  input  wire rgbhsv_pkg::rgbhsv_side_t  num_side,
  output logic                           quo_vld,
  output logic [rgbhsv_pkg::QUO_W-1:0]   quo,
  output rgbhsv_pkg::rgbhsv_side_t       quo_side
);
  import rgbhsv_pkg::*;

  logic             vld_r  [DIV_STAGES];
  logic [NUM_W-1:0] rem_r  [DIV_STAGES];
  logic [QUO_W-1:0] quo_r  [DIV_STAGES];
  rgbhsv_side_t     side_r [DIV_STAGES];

  for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stage
    localparam int K_LO = QUO_W - BITS_PER_STAGE * (st + 1);
    localparam int K_HI = K_LO + 1;

    logic             src_vld;
    logic [NUM_W-1:0] src_rem;
    logic [QUO_W-1:0] src_quo;
    rgbhsv_side_t     src_side;
    logic [NUM_W-1:0] dvs_hi, dvs_lo, rem_a, rem_b;
    logic             bit_hi, bit_lo;

    if (st == 0) begin : g_first
      assign src_vld  = num_vld;
      assign src_rem  = num;
      assign src_quo  = '0;
      assign src_side = num_side;
    end else begin : g_next
      assign src_vld  = vld_r[st-1];
      assign src_rem  = rem_r[st-1];
      assign src_quo  = quo_r[st-1];
      assign src_side = side_r[st-1];
    end

    // Two trial subtractions of the shifted divisor
    always_comb begin
      dvs_hi = NUM_W'(src_side.span) << K_HI;
      bit_hi = src_rem >= dvs_hi;
      rem_a  = bit_hi ? (src_rem - dvs_hi) : src_rem;
      dvs_lo = NUM_W'(src_side.span) << K_LO;
      bit_lo = rem_a >= dvs_lo;
      rem_b  = bit_lo ? (rem_a - dvs_lo) : rem_a;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[st] <= 1'b0;
      end else begin
        vld_r[st] <= src_vld;
      end
      rem_r[st]  <= rem_b;
      quo_r[st]  <= src_quo | (QUO_W'({bit_hi, bit_lo}) << K_LO);
      side_r[st] <= src_side;
    end
  end

  assign quo_vld  = vld_r[DIV_STAGES-1];
  assign quo      = quo_r[DIV_STAGES-1];
  assign quo_side = side_r[DIV_STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/rgb_to_hsv_byte_converter_core.sv -----
`default_nettype none

// RGB to HSV byte converter. One pixel per beat: a pixel is taken at every
// clock edge with start high (busy is never raised), and its result appears
// on out_result with out_valid high for one cycle once it has passed every
// pipeline register. Sustained rate is one pixel per clock; the pipeline is
// two front stages (max/min and the x43 scale), three divider stages at two
// quotient bits each, and the output register. brightness is the largest
// channel, saturation is max minus min (unscaled), hue is the sector base
// (0, 85, 171; ties go red, then green, then blue) plus or minus
// 43*|diff|/(max-min) truncated, modulo 256; a grey pixel gives hue 0.
// Results cannot be held off and must be taken when out_valid is high.
module rgb_to_hsv_byte_converter_core (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire rgbhsv_pkg::rgbhsv_in_t  in_pixel,
  output logic                         out_valid,
  output rgbhsv_pkg::rgbhsv_out_t      out_result
);
  import rgbhsv_pkg::*;

  logic             num_vld;
  logic [NUM_W-1:0] num;
  rgbhsv_side_t     num_side;
  logic             quo_vld;
  logic [QUO_W-1:0] quo;
  rgbhsv_side_t     quo_side;

  logic        out_valid_r;
  rgbhsv_out_t out_res_r, out_res_nxt;

  // Fully pipelined; never stalls
  assign busy = 1'b0;

  rgbhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_pix   (in_pixel),
    .num_vld  (num_vld),
    .num      (num),
    .num_side (num_side)
  );

  rgbhsv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .num_vld  (num_vld),
    .num      (num),
    .num_side (num_side),
    .quo_vld  (quo_vld),
    .quo      (quo),
    .quo_side (quo_side)
  );

  // Apply signed offset to the sector base, wrapping mod 256.
  // Grey pixel: the divisor is zero, so the quotient is meaningless; hue is 0.
  always_comb begin
    out_res_nxt.hue = (quo_side.span == 8'd0) ? 8'd0 :
                      quo_side.neg ? (quo_side.base - 8'(quo))
                                   : (quo_side.base + 8'(quo));
    out_res_nxt.saturation = quo_side.span;
    out_res_nxt.brightness = quo_side.mx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= quo_vld;
    end
    out_res_r <= out_res_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_res_r;

  // Every accepted pixel produces a result on out_valid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("accepted beat did not produce a result");

  // No result without a pixel having been taken
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_LAT))
    else $error("result without an accepted beat");

  // Grey pixel gives hue zero
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.saturation == 8'd0) |-> out_result.hue == 8'd0)
    else $error("grey pixel with nonzero hue");

  // Span can never exceed the maximum channel
  a_sat_le_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.saturation <= out_result.brightness)
    else $error("saturation above brightness");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import rgbhsv_pkg::*;

  // pixel in flight with the hue/sat/value it must come back as
  typedef struct {
    rgbhsv_in_t  px;
    rgbhsv_out_t hsv;
  } hsv_pending_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  rgbhsv_in_t  in_pixel = '0;
  logic        out_valid;
  rgbhsv_out_t out_result;

  hsv_pending_t hsv_due_q[$];
  int           mismatch_count = 0;

  // corner pixels, packed as 24'hRRGGBB
  logic [23:0] corner_px [22] = '{
    24'h000000, 24'hFFFFFF, 24'h808080,              // black, white, grey
    24'hFF0000, 24'h00FF00, 24'h0000FF,              // primaries
    24'hFFFF00, 24'h00FFFF, 24'hFF00FF,              // max ties
    24'hFF000A, 24'hFF0A00, 24'h0AFF00, 24'h00FF0A,  // diff sign per sector
    24'h0A00FF, 24'h000AFF,
    24'h656464, 24'h646465, 24'h646564,              // span of one
    24'h55AA55, 24'hAA55AA,                          // alternating bits
    24'hC801C7, 24'h01C8C7                           // near-full offset, negative then positive
  };

  rgb_to_hsv_byte_converter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_pixel   (in_pixel),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hue/saturation/value of one pixel
  function automatic rgbhsv_out_t hsv_of(input rgbhsv_in_t px);
    int r, g, b, mx, mn, span, base, a, c, mag, q, h;
    rgbhsv_out_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    span = mx - mn;
    h = 0;
    if (span != 0) begin
      // red wins ties over green, green over blue
      if (mx == r) begin
        base = BASE_RED;
        a = g;
        c = b;
      end else if (mx == g) begin
        base = BASE_GREEN;
        a = b;
        c = r;
      end else begin
        base = BASE_BLUE;
        a = r;
        c = g;
      end
      mag = (a < c) ? c - a : a - c;
      q = (int'(HUE_STEP) * mag) / span;  // truncates toward zero on the magnitude
      h = (a < c) ? base - q : base + q;
    end
    res.hue        = 8'(h);
    res.saturation = 8'(span);
    res.brightness = 8'(mx);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input rgbhsv_in_t px,
                                 input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t ERROR %s: pixel r=%0d g=%0d b=%0d want %0d got %0d",
               $time, what, px.red, px.green, px.blue, want, got);
  endtask

  // result check and pixel capture on every edge
  always @(posedge clk) begin : hsv_monitor
    hsv_pending_t pend;
    if (rst_n) begin
      if (out_valid) begin
        if (hsv_due_q.size() == 0) begin
          report_mismatch("result with no pixel pending", '0, 0, int'(out_result));
        end else begin
          pend = hsv_due_q.pop_front();
          if (out_result.hue != pend.hsv.hue)
            report_mismatch("hue", pend.px, pend.hsv.hue, out_result.hue);
          if (out_result.saturation != pend.hsv.saturation)
            report_mismatch("saturation", pend.px, pend.hsv.saturation,
                            out_result.saturation);
          if (out_result.brightness != pend.hsv.brightness)
            report_mismatch("brightness", pend.px, pend.hsv.brightness,
                            out_result.brightness);
        end
      end
      if (start && !busy) begin
        pend.px  = in_pixel;
        pend.hsv = hsv_of(in_pixel);
        hsv_due_q.push_back(pend);
      end
    end
  end

  // one beat; start stays high so the next send can follow back to back
  task automatic send_pixel(input rgbhsv_in_t px);
    start    <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // start low for the given idle stretch, junk on the pixel bus meanwhile
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start    <= 1'b0;
      in_pixel <= rgbhsv_in_t'(24'($urandom));
      repeat (n) @(posedge clk);
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  function automatic rgbhsv_in_t rand_pixel();
    rgbhsv_in_t px;
    int base, hi, lo, pick;
    px = rgbhsv_in_t'(24'($urandom));
    case ($urandom_range(0, 9))
      5, 6: begin
        // nearly grey: tiny span stresses the divider
        base = $urandom_range(0, 250);
        px.red   = 8'(base + $urandom_range(0, 5));
        px.green = 8'(base + $urandom_range(0, 5));
        px.blue  = 8'(base + $urandom_range(0, 5));
      end
      7: begin
        // two channels tied at the max
        hi = $urandom_range(1, 255);
        lo = $urandom_range(0, hi);
        pick = $urandom_range(0, 2);
        px.red   = 8'((pick == 2) ? lo : hi);
        px.green = 8'((pick == 1) ? lo : hi);
        px.blue  = 8'((pick == 0) ? lo : hi);
      end
      8: begin
        px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue  = $urandom_range(0, 2) == 0 ? 8'($urandom) :
                   ($urandom_range(0, 1) ? 8'hFF : 8'h00);
      end
      default: ;
    endcase
    return px;
  endfunction

  // hold off until every pending result is back, bounded
  task automatic wait_drained();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (hsv_due_q.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic test_corner_pixels();
    foreach (corner_px[i]) begin
      send_pixel(rgbhsv_in_t'(corner_px[i]));
      idle_cycles(i % 3);
    end
  endtask

  task automatic test_back_to_back();
    repeat (200) send_pixel(rand_pixel());
  endtask

  task automatic test_random_traffic();
    repeat (1300) begin
      send_pixel(rand_pixel());
      idle_cycles(pick_gap());
    end
  endtask

  task automatic test_pause_until_drained();
    repeat (4) begin
      repeat (50) begin
        send_pixel(rand_pixel());
        idle_cycles(pick_gap());
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_pixels();
    test_back_to_back();
    test_random_traffic();
    test_pause_until_drained();
    wait_drained();
    repeat (PIPE_LAT + 4) @(posedge clk);
    while (hsv_due_q.size() != 0) begin
      report_mismatch("no result for pixel", hsv_due_q[0].px,
                      int'(hsv_due_q[0].hsv), 0);
      void'(hsv_due_q.pop_front());
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/rgbhsv_pkg.sv
rtl/rgbhsv_front.sv
rtl/rgbhsv_div.sv
rtl/rgb_to_hsv_byte_converter_core.sv
verif/tb_top.sv
